[hdl/single_precision_multiplier_assert.svh]
// Assertion macros for the single-precision multiplier.
// Each macro expects clk and arst_n in scope.
`ifndef SINGLE_PRECISION_MULTIPLIER_ASSERT_SVH
`define SINGLE_PRECISION_MULTIPLIER_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define SPM_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition holds whenever a qualifier is high.
`define SPM_ASSERT_WHEN(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

[hdl/spm_pkg.sv]
// ---------------------------------------------------------------------------
// spm_pkg
// Types and constants shared by the single-precision multiplier stages.
// ---------------------------------------------------------------------------
`default_nettype none

package spm_pkg;

	localparam int unsigned FracW = 23;
	localparam int unsigned ExpW = 8;
	localparam int unsigned LowBits = 10;
	localparam int unsigned HighBits = FracW + 1 - LowBits;
	localparam int unsigned ProdW = 2 * HighBits;
	localparam int unsigned EW = 10;

	localparam logic [ExpW-1:0] ExpAll1 = 8'd255;
	localparam logic [ExpW-1:0] ExpZero = 8'd0;
	localparam logic signed [EW-1:0] ExpBias = 10'sd127;
	localparam logic signed [EW-1:0] ExpMaxFin = 10'sd254;
	localparam logic [31:0] NanBits = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		SP_NONE,
		SP_NAN,
		SP_INF,
		SP_ZERO
	} special_t;

	// partial products and decoded operands
	typedef struct packed {
		logic sgn;
		special_t special;
		logic signed [EW-1:0] exp;
		logic [ProdW-1:0] pp_hh;
		logic [HighBits-1:0] pp_hl;
		logic [HighBits-1:0] pp_lh;
	} stage1_t;

	// normalized significand with guard, round and sticky
	typedef struct packed {
		logic sgn;
		special_t special;
		logic signed [EW-1:0] exp;
		logic [FracW:0] mant;
		logic g;
		logic r;
		logic s;
	} stage2_t;

endpackage

`default_nettype wire

[hdl/spm_prep.sv]
// ---------------------------------------------------------------------------
// spm_prep
// First stage: decode operands, flag special cases, form partial products.
// ---------------------------------------------------------------------------
`default_nettype none

module spm_prep import spm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic out_valid,
	input  wire logic out_ready,
	output stage1_t out_data
);

	logic valid_s1;
	stage1_t data_s1;
	stage1_t nxt;
	logic [ExpW-1:0] ex, ey;
	logic [FracW-1:0] fx, fy;
	logic [FracW:0] mx, my;
	logic [2*HighBits-1:0] hl_full, lh_full;

	always_comb begin
		ex = a[30:23];
		ey = b[30:23];
		fx = a[FracW-1:0];
		fy = b[FracW-1:0];
		mx = {1'b1, fx};
		my = {1'b1, fy};
		nxt.sgn = a[31] ^ b[31];
		priority if ((ex == ExpAll1 && fx != '0) || (ey == ExpAll1 && fy != '0) ||
				(ex == ExpAll1 && ey == ExpZero) || (ex == ExpZero && ey == ExpAll1)) begin
			nxt.special = SP_NAN;
		end else if (ex == ExpAll1 || ey == ExpAll1) begin
			nxt.special = SP_INF;
		end else if (ex == ExpZero || ey == ExpZero) begin
			nxt.special = SP_ZERO;
		end else begin
			nxt.special = SP_NONE;
		end
		nxt.exp = $signed({2'b00, ex}) + $signed({2'b00, ey}) - ExpBias;
		nxt.pp_hh = mx[FracW:LowBits] * my[FracW:LowBits];
		hl_full = mx[FracW:LowBits] * {4'b0, my[LowBits-1:0]};
		lh_full = {4'b0, mx[LowBits-1:0]} * my[FracW:LowBits];
		// drop the low bits of the cross products
		nxt.pp_hl = hl_full[2*HighBits-1-(HighBits-LowBits) -: HighBits];
		nxt.pp_lh = lh_full[2*HighBits-1-(HighBits-LowBits) -: HighBits];
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data = data_s1;

endmodule

`default_nettype wire

[hdl/spm_norm.sv]
// ---------------------------------------------------------------------------
// spm_norm
// Second stage: sum partial products, normalize, extract guard/round/sticky.
// ---------------------------------------------------------------------------
`default_nettype none

module spm_norm import spm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  stage1_t in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output stage2_t out_data
);

	logic valid_s2;
	stage2_t data_s2;
	stage2_t nxt;
	logic [ProdW-1:0] prod;

	always_comb begin
		prod = in_data.pp_hh + {{(ProdW-HighBits){1'b0}}, in_data.pp_hl}
			+ {{(ProdW-HighBits){1'b0}}, in_data.pp_lh};
		nxt.sgn = in_data.sgn;
		nxt.special = in_data.special;
		if (prod[ProdW-1]) begin
			nxt.exp = in_data.exp + 10'sd1;
			nxt.mant = prod[ProdW-1:4];
			nxt.g = prod[3];
			nxt.r = prod[2];
			nxt.s = prod[1] | prod[0];
		end else begin
			nxt.exp = in_data.exp;
			nxt.mant = prod[ProdW-2:3];
			nxt.g = prod[2];
			nxt.r = prod[1];
			nxt.s = prod[0];
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = data_s2;

endmodule

`default_nettype wire

[hdl/spm_round.sv]
// ---------------------------------------------------------------------------
// spm_round
// Third stage: round to nearest even, check range, pack the result word.
// ---------------------------------------------------------------------------
`default_nettype none

module spm_round import spm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  stage2_t in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [31:0] out_bits
);

	logic valid_s3;
	logic [31:0] bits_s3;
	logic [31:0] nxt;
	logic inc;
	logic [FracW+1:0] m25;
	logic signed [EW-1:0] e;

	always_comb begin
		inc = in_data.g && (in_data.r || in_data.s || in_data.mant[0]);
		m25 = {1'b0, in_data.mant} + {{(FracW+1){1'b0}}, inc};
		e = in_data.exp + $signed({{(EW-1){1'b0}}, m25[FracW+1]});
		unique case (in_data.special)
			SP_NAN: nxt = NanBits;
			SP_INF: nxt = {in_data.sgn, ExpAll1, {FracW{1'b0}}};
			SP_ZERO: nxt = {in_data.sgn, ExpZero, {FracW{1'b0}}};
			default: begin
				priority if (e > ExpMaxFin) begin
					nxt = {in_data.sgn, ExpAll1, {FracW{1'b0}}};
				end else if (e <= 10'sd0) begin
					nxt = {in_data.sgn, ExpZero, {FracW{1'b0}}};
				end else begin
					nxt = {in_data.sgn, e[ExpW-1:0], m25[FracW-1:0]};
				end
			end
		endcase
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bits_s3 <= nxt;
		end
	end

	assign out_valid = valid_s3;
	assign out_bits = bits_s3;

endmodule

`default_nettype wire

[hdl/single_precision_multiplier.sv]
// ---------------------------------------------------------------------------
// single_precision_multiplier
// Binary32 multiplier, flush-to-zero, truncated significand product.
// ---------------------------------------------------------------------------
// Takes one word of two operands per cycle and returns one product word per
// cycle while m_tready is high; each word passes through the register stages
// in order (partial products, sum and normalize, round and pack). A stalled
// output holds only the stages that are full, so bubbles are squeezed out.
`default_nettype none

module single_precision_multiplier import spm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [63:0] s_tdata, // operand_a[31:0], operand_b[63:32]
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [31:0] m_tdata // product_bits[31:0]
);

	`include "single_precision_multiplier_assert.svh"

	logic v1, r2, v2, r3;
	stage1_t d1;
	stage2_t d2;

	spm_prep u_prep (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.a(s_tdata[31:0]), .b(s_tdata[63:32]),
		.out_valid(v1), .out_ready(r2), .out_data(d1)
	);

	spm_norm u_norm (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v1), .in_ready(r2), .in_data(d1),
		.out_valid(v2), .out_ready(r3), .out_data(d2)
	);

	spm_round u_round (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v2), .in_ready(r3), .in_data(d2),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_bits(m_tdata)
	);

	`SPM_ASSERT(a_s1_hold, (v1 && !r2) |=> (v1 && $stable(d1)), "stage 1 lost a stalled word")
	`SPM_ASSERT_WHEN(a_norm_msb, v2 && d2.special == SP_NONE, d2.mant[FracW], "significand not normalized")
	`SPM_ASSERT_WHEN(a_all1_exp, m_tvalid && m_tdata[30:23] == ExpAll1, m_tdata[22:0] == '0 || m_tdata == NanBits, "bad infinity or NaN encoding")

endmodule

`default_nettype wire

[test/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Stream test of the binary32 multiplier: operand words are fed with random
// gaps and output stalls, each product is predicted bit for bit and compared
// in order against the words the block returns.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
	import spm_pkg::*;

	class product_board;
		logic [31:0] pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// truncated-significand product, flush-to-zero, round to nearest even
		function automatic logic [31:0] mul_bits(logic [31:0] x, logic [31:0] y);
			logic sx, sy, sgn, st;
			logic [7:0] ex, ey;
			logic [22:0] fx, fy;
			logic [23:0] mx, my;
			logic [13:0] hx, hy;
			logic [9:0] lx, ly;
			logic [63:0] prod;
			logic [24:0] mant;
			logic [2:0] grs;
			int e;
			sx = x[31]; sy = y[31]; sgn = sx ^ sy;
			ex = x[30:23]; ey = y[30:23];
			fx = x[22:0]; fy = y[22:0];
			if ((ex == ExpAll1 && fx != 0) || (ey == ExpAll1 && fy != 0))
				return NanBits;
			if ((ex == ExpAll1 && ey == ExpZero) || (ex == ExpZero && ey == ExpAll1))
				return NanBits;
			if (ex == ExpAll1 || ey == ExpAll1)
				return {sgn, ExpAll1, 23'd0};
			if (ex == ExpZero || ey == ExpZero)
				return {sgn, 31'd0};
			e = int'(ex) + int'(ey) - 127;
			mx = {1'b1, fx}; my = {1'b1, fy};
			hx = mx[23:10]; hy = my[23:10];
			lx = mx[9:0]; ly = my[9:0];
			prod = 64'(hx) * 64'(hy) + ((64'(hx) * 64'(ly)) >> 10)
				+ ((64'(lx) * 64'(hy)) >> 10);
			if (prod[27]) begin
				st = prod[1:0] != 0;
				prod = ((prod >> 2) << 1) | 64'(st);
				e++;
			end
			mant = {1'b0, prod[26:3]};
			grs = prod[2:0];
			if (grs[2] && (grs[1:0] != 0 || mant[0])) begin
				mant++;
				if (mant[24])
					e++;
			end
			if (e > 254)
				return {sgn, ExpAll1, 23'd0};
			if (e <= 0)
				return {sgn, 31'd0};
			return {sgn, e[7:0], mant[22:0]};
		endfunction

		function void note_operands(logic [31:0] a, logic [31:0] b);
			pending.push_back(mul_bits(a, b));
		endfunction

		function void check_product(logic [31:0] got);
			logic [31:0] want;
			if (pending.size() == 0) begin
				$error("product_bits: unexpected word %h", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$error("product_bits: expected %h actual %h", want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [63:0] s_tdata;
	logic [31:0] m_tdata;

	product_board board;
	int sent;
	bit calm, hold_off;

	single_precision_multiplier dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end

	function automatic logic [31:0] rand_float();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: v[30:23] = 8'd255;
			1: v[30:23] = 8'd0;
			2: v[30:23] = 8'($urandom_range(190, 254));
			3: v[30:23] = 8'($urandom_range(1, 64));
			4: v[22:0] = $urandom_range(0, 1) ? 23'd0 : 23'h7FFFFF;
			default: v[30:23] = 8'($urandom_range(100, 154));
		endcase
		return v;
	endfunction

	task automatic send_word(logic [31:0] a, logic [31:0] b);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_operands(a, b);
		sent++;
	endtask

	// receiver: random stalls, one long hold-off while the sender keeps offering
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_product(m_tdata);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (60) @(posedge clk);
				hold_off = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 19);
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		logic [31:0] edge_vals[$];
		int wait_cycles;
		board = new();
		sent = 0;
		calm = 0;
		hold_off = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zeros, denormals, infinities, NaNs, extremes, rounding and overflow corners
		edge_vals = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7F80_0000,
			32'hFF80_0000, 32'h7FC0_0000, 32'hFF80_0001, 32'h3F80_0000,
			32'hBFFF_FFFF, 32'h7F7F_FFFF, 32'h0080_0000, 32'h3FFF_FFFF};
		foreach (edge_vals[i])
			send_word(edge_vals[i], edge_vals[(i * 5 + 3) % edge_vals.size()]);
		send_word(32'h7F80_0000, 32'h0000_0000);
		send_word(32'h0000_0001, 32'hFF80_0000);
		send_word(32'h7F00_0000, 32'h7F00_0000);
		send_word(32'h2000_0000, 32'h1F00_0000);
		send_word(32'h0080_0000, 32'h3F00_0000);
		send_word(32'hFFFF_FFFF, 32'h0000_0000);
		send_word(32'h3FB5_04F3, 32'h3FB5_04F3);
		send_word(32'h3F80_0001, 32'hBF7F_FFFF);

		for (int i = 0; i < 850; i++) begin
			if (i == 300)
				hold_off = 1;
			if (i == 700)
				calm = 1;
			send_word(rand_float(), rand_float());
		end
		s_tvalid <= 1'b0;

		wait_cycles = 0;
		while (board.pending.size() != 0 && wait_cycles < 10000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
